// ===== sv/gbn_pkg.sv =====
`timescale 1ns / 1ps

package gbn_pkg;

  // Fixed sizes of the transfer
  localparam int unsigned MaxWindow  = 32;
  localparam int unsigned ChunkBytes = 1024;
  localparam int unsigned BurstLimit = 32;

  localparam int unsigned CntW   = 17;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned BytesW = 11;
  localparam int unsigned WinW   = 6;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BurstW = 6;

  // Reset values of the configuration registers
  localparam logic [SeqW-1:0]   ChunkCountRst = 16'd1;
  localparam logic [BytesW-1:0] LastBytesRst  = 11'd1024;
  localparam logic [WinW-1:0]   InitWindowRst = 6'd3;

  typedef logic [CntW-1:0] cnt_t;

  // Event codes on the request channel
  typedef enum logic [FuncW-1:0] {
    FUNC_START   = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHUNK_COUNT = 2'd0,
    CFG_LAST_BYTES  = 2'd1,
    CFG_INIT_WINDOW = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // Decoded operation handed from front to back
  typedef enum logic [3:0] {
    OP_RESTART = 4'b0001,
    OP_ACK     = 4'b0010,
    OP_REWIND  = 4'b0100,
    OP_HOLD    = 4'b1000
  } op_e;

  typedef struct packed {
    op_e  op;
    cnt_t ack_cnt;
  } cmd_t;

  typedef struct packed {
    logic [SeqW-1:0]   chunk_count;
    logic [BytesW-1:0] last_bytes;
    logic [WinW-1:0]   init_window;
  } cfg_t;

  typedef struct packed {
    logic              send_valid;
    logic [SeqW-1:0]   seq_no;
    logic [BytesW-1:0] payload_bytes;
    logic [WinW-1:0]   window_now;
    logic              ack_ignored;
    logic              all_done;
    logic              last;
  } res_t;

  // Keep a window value within 1..MaxWindow
  function automatic logic [WinW-1:0] clamp_window(input logic [WinW-1:0] w);
    logic [WinW-1:0] r;
    if (w == '0) begin
      r = WinW'(1);
    end else if (w > WinW'(MaxWindow)) begin
      r = WinW'(MaxWindow);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ===== sv/gobackn_window_sender.sv =====
`timescale 1ns / 1ps

// Go-back-N transmit scheduler with a congestion window. Each request is a
// start, an ACK, a timeout or a no-op event; the block answers with one
// or more results: one send command per chunk the window allows (up to 32),
// or a single no-send result, the final one marked by last_o. Events pass
// through a two-entry queue to a sequencer that first applies the event and
// then issues its results in turn; it takes no new event until the final
// result of the current one is issued. The sequencer issues one result per
// cycle while the output is not back-pressured. Configuration writes take
// effect at once and belong in idle periods.
// No start-up pass: the block behaves as started right after reset.
module gobackn_window_sender import gbn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [SeqW-1:0]     ack_seq_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                send_valid_o,
  output logic [SeqW-1:0]     seq_no_o,
  output logic [BytesW-1:0]   payload_bytes_o,
  output logic [WinW-1:0]     window_now_o,
  output logic                ack_ignored_o,
  output logic                all_done_o,
  output logic                last_o
);

  cfg_t cfg_q, cfg_d;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHUNK_COUNT: cfg_d.chunk_count = cfg_data_i[SeqW-1:0];
        CFG_LAST_BYTES:  cfg_d.last_bytes  = cfg_data_i[BytesW-1:0];
        CFG_INIT_WINDOW: cfg_d.init_window = cfg_data_i[WinW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_count <= ChunkCountRst;
      cfg_q.last_bytes  <= LastBytesRst;
      cfg_q.init_window <= InitWindowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .ack_seq_i   (ack_seq_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign send_valid_o    = res.send_valid;
  assign seq_no_o        = res.seq_no;
  assign payload_bytes_o = res.payload_bytes;
  assign window_now_o    = res.window_now;
  assign ack_ignored_o   = res.ack_ignored;
  assign all_done_o      = res.all_done;
  assign last_o          = res.last;

  // Window reported stays within its legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_now_o != '0) && (window_now_o <= WinW'(MaxWindow)))
    else $error("window out of range");

  // Only send results can be followed by more results of the same event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> send_valid_o)
    else $error("non-final result without send");

  // A no-send result carries no chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !send_valid_o) |-> (seq_no_o == '0) && (payload_bytes_o == '0))
    else $error("no-send result with payload");

  // A send never names a chunk beyond the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_valid_o) |-> (seq_no_o < cfg_q.chunk_count))
    else $error("send beyond transfer");

endmodule

// ===== sv/gbn_front.sv =====
`timescale 1ns / 1ps

module gbn_front import gbn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FuncW-1:0] func_i,
  input  logic [SeqW-1:0]  ack_seq_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cmd_t             cmd_o
);

  localparam int unsigned QDepth = 2;

  cmd_t       cmd_in;
  cmd_t       q_mem_q [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  // Classify the incoming event
  always_comb begin
    case (func_e'(func_i))
      FUNC_START:   cmd_in.op = OP_RESTART;
      FUNC_ACK:     cmd_in.op = OP_ACK;
      FUNC_TIMEOUT: cmd_in.op = OP_REWIND;
      default:      cmd_in.op = OP_HOLD;
    endcase
    cmd_in.ack_cnt = {1'b0, ack_seq_i} + cnt_t'(1);
  end

  // Short queue toward the back end
  assign in_ready_o  = (count_q != 2'(QDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/gbn_back.sv =====
`timescale 1ns / 1ps

module gbn_back import gbn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } st_e;

  st_e               state_q, state_d;
  cnt_t              sent_q, sent_d;
  cnt_t              acked_q, acked_d;
  logic [WinW-1:0]   win_q, win_d;
  logic              ign_q, ign_d;
  logic [BurstW-1:0] n_q, n_d;
  logic              ov_q, ov_d;
  res_t              res_q, res_d;

  cnt_t              chunk_cnt, nxt, ack_diff, win_sum;
  logic [BytesW-1:0] last_bytes;
  logic              out_free, can_send, more, ack_ok;

  assign chunk_cnt  = {1'b0, cfg_i.chunk_count};
  assign last_bytes = (cfg_i.last_bytes > BytesW'(ChunkBytes)) ? BytesW'(ChunkBytes)
                                                               : cfg_i.last_bytes;
  assign nxt        = sent_q + cnt_t'(1);
  assign out_free   = !ov_q || out_ready_i;

  // Window check for the current and the following chunk
  assign can_send = (n_q < BurstW'(BurstLimit)) && (sent_q < chunk_cnt) &&
                    (sent_q >= acked_q) && ((sent_q - acked_q) < cnt_t'(win_q));
  assign more     = (n_q < BurstW'(BurstLimit - 1)) && (nxt < chunk_cnt) &&
                    (nxt >= acked_q) && ((nxt - acked_q) < cnt_t'(win_q));

  // Acknowledge range and window growth
  assign ack_ok   = (cmd_i.ack_cnt > acked_q) && (cmd_i.ack_cnt <= sent_q);
  assign ack_diff = cmd_i.ack_cnt - acked_q;
  assign win_sum  = cnt_t'(win_q) + ack_diff;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    sent_d  = sent_q;
    acked_d = acked_q;
    win_d   = win_q;
    ign_d   = ign_q;
    n_d     = n_q;
    ov_d    = ov_q;
    res_d   = res_q;

    // drop the result once taken
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // apply the event to the transfer state
        if (cmd_valid_i) begin
          ign_d   = 1'b0;
          n_d     = '0;
          state_d = ST_BURST;
          case (cmd_i.op)
            OP_RESTART: begin
              sent_d  = '0;
              acked_d = '0;
              win_d   = clamp_window(cfg_i.init_window);
            end
            OP_ACK: begin
              if (ack_ok) begin
                acked_d = cmd_i.ack_cnt;
                win_d   = (win_sum > cnt_t'(MaxWindow)) ? WinW'(MaxWindow)
                                                        : win_sum[WinW-1:0];
              end else begin
                ign_d = 1'b1;
              end
            end
            OP_REWIND: begin
              sent_d = acked_q;
              win_d  = (win_q > WinW'(1)) ? (win_q >> 1) : WinW'(1);
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        // issue one result per cycle while the output is free, until the window or burst limit ends the burst
        if (out_free) begin
          ov_d              = 1'b1;
          res_d.send_valid  = can_send;
          res_d.seq_no      = can_send ? sent_q[SeqW-1:0] : '0;
          res_d.payload_bytes = !can_send ? '0 :
                                (nxt == chunk_cnt) ? last_bytes : BytesW'(ChunkBytes);
          res_d.window_now  = win_q;
          res_d.ack_ignored = ign_q;
          res_d.all_done    = (acked_q >= chunk_cnt);
          res_d.last        = !can_send || !more;
          if (can_send) begin
            sent_d = nxt;
            n_d    = n_q + BurstW'(1);
          end
          if (!can_send || !more) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sent_q  <= '0;
      acked_q <= '0;
      win_q   <= clamp_window(InitWindowRst);
      ign_q   <= 1'b0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sent_q  <= sent_d;
      acked_q <= acked_d;
      win_q   <= win_d;
      ign_q   <= ign_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

endmodule
